// ===== hw/rtl/text_cell_glyph_renderer_macros.svh =====
// assertion helpers, all sampled on clock and disabled during reset
`ifndef TEXT_CELL_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CELL_GLYPH_RENDERER_MACROS_SVH

`define TCGR_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`define TCGR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps

package tcgr_pkg;

   localparam int unsigned CELL_W      = 6;
   localparam int unsigned CELL_H      = 10;
   localparam int unsigned GLYPH_W     = 5;
   localparam int unsigned GLYPH_H     = 8;
   localparam int unsigned UNDER_ROW   = 8;
   localparam int unsigned CELL_PIXELS = CELL_W * CELL_H;
   localparam int unsigned PIX_IDX_W   = $clog2(CELL_PIXELS);
   localparam int unsigned PX_W        = $clog2(CELL_W);

   localparam int unsigned MAX_COLUMNS = 96;
   localparam int unsigned MAX_ROWS    = 43;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_32BIT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_STRIDE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMNS_IN_USE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_IN_USE    = 3'd5;

   localparam logic [31:0] FG_16 = 32'h0000_ffff;
   localparam logic [31:0] BG_16 = 32'h0000_0001;
   localparam logic [31:0] FG_32 = 32'hffff_ffff;
   localparam logic [31:0] BG_32 = 32'h0000_00ff;

   localparam logic [7:0] CODE_NUL   = 8'h00;
   localparam logic [7:0] CODE_SPACE = 8'h20;

   typedef logic [CELL_PIXELS-1:0] lit_mask_type;

   typedef struct packed {
      logic        pixel_32bit;
      logic [11:0] line_stride;
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [6:0]  columns_in_use;
      logic [5:0]  rows_in_use;
   } csr_type;

   typedef struct packed {
      logic [6:0] cell_column;
      logic [5:0] cell_row;
      logic [7:0] char_code;
      logic       reverse_video;
      logic       bold_text;
      logic       underline_text;
      logic       cursor_invert;
   } cell_req_type;

   typedef struct packed {
      lit_mask_type lit_mask;
      logic         swap;
      logic         wide;
      logic [23:0]  start_offset;
   } cell_entry_type;

   // column 0 lands in the low byte
   function automatic logic [39:0] glyph_cols(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] c3,
                                              input logic [7:0] c4);
      return {c4, c3, c2, c1, c0};
   endfunction

   function automatic logic [39:0] glyph_bits(input logic [7:0] code);
      logic [39:0] g;
      case (code)
         "0": g = glyph_cols(8'h7e, 8'ha1, 8'h99, 8'h85, 8'h7e);
         "1": g = glyph_cols(8'h84, 8'h82, 8'hff, 8'h80, 8'h80);
         "2": g = glyph_cols(8'hc1, 8'ha1, 8'h91, 8'h89, 8'h86);
         "3": g = glyph_cols(8'h89, 8'h89, 8'h89, 8'h89, 8'h76);
         "4": g = glyph_cols(8'h18, 8'h14, 8'h12, 8'hff, 8'h10);
         "5": g = glyph_cols(8'h8f, 8'h89, 8'h89, 8'h89, 8'h71);
         "6": g = glyph_cols(8'h7e, 8'h89, 8'h89, 8'h89, 8'h72);
         "7": g = glyph_cols(8'h01, 8'h81, 8'h61, 8'h19, 8'h07);
         "8": g = glyph_cols(8'h62, 8'h95, 8'h89, 8'h95, 8'h62);
         "9": g = glyph_cols(8'h4e, 8'h91, 8'h91, 8'h91, 8'h7e);
         "A": g = glyph_cols(8'hfe, 8'h11, 8'h11, 8'h11, 8'hfe);
         "B": g = glyph_cols(8'hff, 8'h89, 8'h89, 8'h89, 8'h76);
         "C": g = glyph_cols(8'h7e, 8'h81, 8'h81, 8'h81, 8'h81);
         "D": g = glyph_cols(8'hff, 8'h81, 8'h81, 8'h81, 8'h7e);
         "E": g = glyph_cols(8'hff, 8'h89, 8'h89, 8'h89, 8'h89);
         "F": g = glyph_cols(8'hff, 8'h09, 8'h09, 8'h09, 8'h09);
         "G": g = glyph_cols(8'h7e, 8'h81, 8'h91, 8'h51, 8'hf1);
         "H": g = glyph_cols(8'hff, 8'h08, 8'h08, 8'h08, 8'hff);
         "I": g = glyph_cols(8'h00, 8'h81, 8'hff, 8'h81, 8'h00);
         "J": g = glyph_cols(8'h40, 8'h80, 8'h80, 8'h80, 8'h7f);
         "K": g = glyph_cols(8'hff, 8'h08, 8'h14, 8'h22, 8'hc1);
         "L": g = glyph_cols(8'hff, 8'h80, 8'h80, 8'h80, 8'h80);
         "M": g = glyph_cols(8'hff, 8'h02, 8'h04, 8'h02, 8'hff);
         "N": g = glyph_cols(8'hff, 8'h06, 8'h18, 8'h60, 8'hff);
         "O": g = glyph_cols(8'h7e, 8'h81, 8'h81, 8'h81, 8'h7e);
         "P": g = glyph_cols(8'hff, 8'h11, 8'h11, 8'h11, 8'h0e);
         "Q": g = glyph_cols(8'h7e, 8'h81, 8'ha1, 8'hc1, 8'hfe);
         "R": g = glyph_cols(8'hff, 8'h11, 8'h11, 8'h11, 8'hee);
         "S": g = glyph_cols(8'h86, 8'h89, 8'h89, 8'h89, 8'h71);
         "T": g = glyph_cols(8'h01, 8'h01, 8'hff, 8'h01, 8'h01);
         "U": g = glyph_cols(8'h7f, 8'h80, 8'h80, 8'h80, 8'h7f);
         "V": g = glyph_cols(8'h1f, 8'h60, 8'h80, 8'h60, 8'h1f);
         "W": g = glyph_cols(8'hff, 8'h40, 8'h20, 8'h40, 8'hff);
         "X": g = glyph_cols(8'hc7, 8'h28, 8'h10, 8'h28, 8'hc7);
         "Y": g = glyph_cols(8'h07, 8'h08, 8'hf0, 8'h08, 8'h07);
         "Z": g = glyph_cols(8'hc1, 8'ha1, 8'h99, 8'h85, 8'h83);
         "a": g = glyph_cols(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
         "b": g = glyph_cols(8'h7f, 8'h48, 8'h44, 8'h44, 8'h38);
         "c": g = glyph_cols(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
         "d": g = glyph_cols(8'h38, 8'h44, 8'h44, 8'h48, 8'h7f);
         "e": g = glyph_cols(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
         "f": g = glyph_cols(8'h08, 8'h7e, 8'h09, 8'h01, 8'h02);
         "g": g = glyph_cols(8'h0c, 8'h52, 8'h52, 8'h52, 8'h3e);
         "h": g = glyph_cols(8'h7f, 8'h08, 8'h04, 8'h04, 8'h78);
         "i": g = glyph_cols(8'h00, 8'h44, 8'h7d, 8'h40, 8'h00);
         "j": g = glyph_cols(8'h20, 8'h40, 8'h44, 8'h3d, 8'h00);
         "k": g = glyph_cols(8'h7f, 8'h10, 8'h28, 8'h44, 8'h00);
         "l": g = glyph_cols(8'h00, 8'h41, 8'h7f, 8'h40, 8'h00);
         "m": g = glyph_cols(8'h7c, 8'h04, 8'h18, 8'h04, 8'h78);
         "n": g = glyph_cols(8'h7c, 8'h08, 8'h04, 8'h04, 8'h78);
         "o": g = glyph_cols(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
         "p": g = glyph_cols(8'h7c, 8'h14, 8'h14, 8'h14, 8'h08);
         "q": g = glyph_cols(8'h08, 8'h14, 8'h14, 8'h18, 8'h7c);
         "r": g = glyph_cols(8'h7c, 8'h08, 8'h04, 8'h04, 8'h08);
         "s": g = glyph_cols(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
         "t": g = glyph_cols(8'h04, 8'h3f, 8'h44, 8'h40, 8'h20);
         "u": g = glyph_cols(8'h3c, 8'h40, 8'h40, 8'h20, 8'h7c);
         "v": g = glyph_cols(8'h1c, 8'h20, 8'h40, 8'h20, 8'h1c);
         "w": g = glyph_cols(8'h3c, 8'h40, 8'h30, 8'h40, 8'h3c);
         "x": g = glyph_cols(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
         "y": g = glyph_cols(8'h0c, 8'h50, 8'h50, 8'h50, 8'h3c);
         "z": g = glyph_cols(8'h44, 8'h64, 8'h54, 8'h4c, 8'h44);
         ".": g = glyph_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
         ",": g = glyph_cols(8'h00, 8'ha0, 8'h60, 8'h00, 8'h00);
         ":": g = glyph_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
         ";": g = glyph_cols(8'h00, 8'hb6, 8'h76, 8'h00, 8'h00);
         "!": g = glyph_cols(8'h00, 8'h00, 8'h5f, 8'h00, 8'h00);
         "-": g = glyph_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
         "_": g = glyph_cols(8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
         "+": g = glyph_cols(8'h08, 8'h08, 8'h3e, 8'h08, 8'h08);
         "=": g = glyph_cols(8'h24, 8'h24, 8'h24, 8'h24, 8'h24);
         "/": g = glyph_cols(8'hc0, 8'h30, 8'h0c, 8'h03, 8'h00);
         "\\": g = glyph_cols(8'h03, 8'h0c, 8'h30, 8'hc0, 8'h00);
         "|": g = glyph_cols(8'h00, 8'h00, 8'hff, 8'h00, 8'h00);
         "(": g = glyph_cols(8'h00, 8'h3c, 8'h42, 8'h81, 8'h00);
         ")": g = glyph_cols(8'h00, 8'h81, 8'h42, 8'h3c, 8'h00);
         "[": g = glyph_cols(8'h00, 8'hff, 8'h81, 8'h81, 8'h00);
         "]": g = glyph_cols(8'h00, 8'h81, 8'h81, 8'hff, 8'h00);
         "<": g = glyph_cols(8'h08, 8'h14, 8'h22, 8'h41, 8'h80);
         ">": g = glyph_cols(8'h80, 8'h41, 8'h22, 8'h14, 8'h08);
         "#": g = glyph_cols(8'h24, 8'hff, 8'h24, 8'hff, 8'h24);
         "*": g = glyph_cols(8'h22, 8'h14, 8'h7f, 8'h14, 8'h22);
         "^": g = glyph_cols(8'h04, 8'h02, 8'h01, 8'h02, 8'h04);
         "'": g = glyph_cols(8'h00, 8'h00, 8'h07, 8'h00, 8'h00);
         "\"": g = glyph_cols(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
         "@": g = glyph_cols(8'h7e, 8'h81, 8'hbd, 8'ha5, 8'h1e);
         "$": g = glyph_cols(8'h44, 8'h8a, 8'hff, 8'h91, 8'h62);
         "%": g = glyph_cols(8'h47, 8'h25, 8'h18, 8'ha4, 8'he2);
         "&": g = glyph_cols(8'h76, 8'h89, 8'h95, 8'h62, 8'hd0);
         // unknown codes get the question mark
         default: g = glyph_cols(8'h02, 8'h01, 8'hb1, 8'h09, 8'h06);
      endcase
      return g;
   endfunction

endpackage

// ===== hw/rtl/tcgr_if.sv =====
`timescale 1ns / 1ps

interface tcgr_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] cell_column;
   logic [5:0] cell_row;
   logic [7:0] char_code;
   logic       reverse_video;
   logic       bold_text;
   logic       underline_text;
   logic       cursor_invert;

   modport source (output valid, cell_column, cell_row, char_code, reverse_video,
                   bold_text, underline_text, cursor_invert, input ready);
   modport sink (input valid, cell_column, cell_row, char_code, reverse_video,
                 bold_text, underline_text, cursor_invert, output ready);
endinterface

interface tcgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_offset;
   logic [31:0] pixel_color;
   logic        last_pixel;

   modport source (output valid, pixel_offset, pixel_color, last_pixel, input ready);
   modport sink (input valid, pixel_offset, pixel_color, last_pixel, output ready);
endinterface

interface tcgr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tcgr_pkg::CSR_INDEX_W-1:0]    index;
   logic [tcgr_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tcgr_cell_prep.sv =====
`timescale 1ns / 1ps

// turns one cell transaction into a queue entry: area check, glyph lookup,
// per-pixel lit mask and the byte offset of the cell's top-left pixel
module tcgr_cell_prep (
   input  tcgr_pkg::csr_type        csr,
   input  tcgr_pkg::cell_req_type   cell_req,
   output logic                     in_area,
   output tcgr_pkg::cell_entry_type entry
);

   logic [6:0]  ncols;
   logic [5:0]  nrows;
   logic        space;
   logic [39:0] glyph;
   logic [10:0] y0;
   logic [10:0] x0;
   logic [22:0] row_base;
   logic [12:0] x_bytes;
   tcgr_pkg::lit_mask_type mask;

   assign ncols = (csr.columns_in_use > 7'(tcgr_pkg::MAX_COLUMNS)) ?
                  7'(tcgr_pkg::MAX_COLUMNS) : csr.columns_in_use;
   assign nrows = (csr.rows_in_use > 6'(tcgr_pkg::MAX_ROWS)) ?
                  6'(tcgr_pkg::MAX_ROWS) : csr.rows_in_use;
   assign in_area = (cell_req.cell_column < ncols) && (cell_req.cell_row < nrows);

   assign space = (cell_req.char_code == tcgr_pkg::CODE_NUL) ||
                  (cell_req.char_code == tcgr_pkg::CODE_SPACE);
   assign glyph = tcgr_pkg::glyph_bits(cell_req.char_code);

   always_comb begin
      logic       lit;
      logic [5:0] ia;
      logic [5:0] ib;
      mask = '0;
      for (int py = 0; py < tcgr_pkg::CELL_H; py++) begin
         for (int px = 0; px < tcgr_pkg::CELL_W; px++) begin
            ia  = 6'(((px < tcgr_pkg::GLYPH_W) ? px : 0) * tcgr_pkg::GLYPH_H +
                     ((py < tcgr_pkg::GLYPH_H) ? py : 0));
            ib  = 6'(((px >= 1 && px < tcgr_pkg::GLYPH_W) ? px - 1 : 0) * tcgr_pkg::GLYPH_H +
                     ((py < tcgr_pkg::GLYPH_H) ? py : 0));
            lit = 1'b0;
            if (px < tcgr_pkg::GLYPH_W && py < tcgr_pkg::GLYPH_H) begin
               lit = glyph[ia];
            end
            // bold smear stays inside the five glyph columns
            if (cell_req.bold_text && px >= 1 && px < tcgr_pkg::GLYPH_W &&
                py < tcgr_pkg::GLYPH_H) begin
               lit = lit | glyph[ib];
            end
            if (cell_req.underline_text && py == tcgr_pkg::UNDER_ROW) begin
               lit = 1'b1;
            end
            mask[tcgr_pkg::PIX_IDX_W'(py * tcgr_pkg::CELL_W + px)] = lit && !space;
         end
      end
   end

   // row * 10 and column * 6 as shift-adds
   assign y0 = 11'(csr.origin_y) + 11'({cell_req.cell_row, 3'b000}) +
               11'({cell_req.cell_row, 1'b0});
   assign x0 = 11'(csr.origin_x) + 11'({cell_req.cell_column, 2'b00}) +
               11'({cell_req.cell_column, 1'b0});
   assign row_base = 23'(y0) * 23'(csr.line_stride);
   assign x_bytes  = csr.pixel_32bit ? {x0, 2'b00} : {1'b0, x0, 1'b0};

   assign entry.lit_mask     = mask;
   assign entry.swap         = cell_req.reverse_video ^ cell_req.cursor_invert;
   assign entry.wide         = csr.pixel_32bit;
   assign entry.start_offset = 24'(row_base) + 24'(x_bytes);

endmodule

// ===== hw/rtl/text_cell_glyph_renderer.sv =====
`timescale 1ns / 1ps

// channel   dir  payload
// req_if    in   cell_column, cell_row, char_code, reverse_video, bold_text,
//                underline_text, cursor_invert
// rsp_if    out  pixel_offset, pixel_color, last_pixel
// csr_if    in   index, data (register write)
//
// A cell that lies inside the text area yields 60 pixel transactions, one per
// cycle from the pixel walker while rsp_if does not stall it; the walker
// loads the next cell from the queue memory in the cycle of the last pixel.
// A new cell passes the queue head register and the walker before its first pixel leaves the output register.
// Up to four cells wait in the queue; req_if.ready drops only when it is full.
// rsp_if stalls hold the output register and the walker, nothing is lost.
// Synchronous reset empties the queue, stops the walker, drops rsp valid and loads the registers with defaults.
module text_cell_glyph_renderer (
   input  logic clock,
   input  logic reset,
   tcgr_req_if.sink   req_if,
   tcgr_rsp_if.source rsp_if,
   tcgr_csr_if.sink   csr_if
);

   localparam logic [tcgr_pkg::QPTR_W:0]      QUEUE_FULL =
      (tcgr_pkg::QPTR_W + 1)'(tcgr_pkg::QUEUE_DEPTH);
   localparam logic [tcgr_pkg::PIX_IDX_W-1:0] LAST_IDX   =
      tcgr_pkg::PIX_IDX_W'(tcgr_pkg::CELL_PIXELS - 1);
   localparam logic [tcgr_pkg::PX_W-1:0]      LAST_PX    =
      tcgr_pkg::PX_W'(tcgr_pkg::CELL_W - 1);

   // registers
   tcgr_pkg::csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            tcgr_pkg::REG_PIXEL_32BIT:    csr_in.pixel_32bit    = csr_if.data[0];
            tcgr_pkg::REG_LINE_STRIDE:    csr_in.line_stride    = csr_if.data[11:0];
            tcgr_pkg::REG_ORIGIN_X:       csr_in.origin_x       = csr_if.data[9:0];
            tcgr_pkg::REG_ORIGIN_Y:       csr_in.origin_y       = csr_if.data[9:0];
            tcgr_pkg::REG_COLUMNS_IN_USE: csr_in.columns_in_use = csr_if.data[6:0];
            tcgr_pkg::REG_ROWS_IN_USE:    csr_in.rows_in_use    = csr_if.data[5:0];
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // cell prep
   tcgr_pkg::cell_req_type   cell_req;
   tcgr_pkg::cell_entry_type entry;
   logic                     in_area;

   assign cell_req.cell_column    = req_if.cell_column;
   assign cell_req.cell_row       = req_if.cell_row;
   assign cell_req.char_code      = req_if.char_code;
   assign cell_req.reverse_video  = req_if.reverse_video;
   assign cell_req.bold_text      = req_if.bold_text;
   assign cell_req.underline_text = req_if.underline_text;
   assign cell_req.cursor_invert  = req_if.cursor_invert;

   tcgr_cell_prep u_prep (
      .csr      (csr_ff),
      .cell_req (cell_req),
      .in_area  (in_area),
      .entry    (entry)
   );

   // cell queue memory
   tcgr_pkg::cell_entry_type queue_mem [tcgr_pkg::QUEUE_DEPTH];
   tcgr_pkg::cell_entry_type head_ff;
   logic [tcgr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcgr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcgr_pkg::QPTR_W:0]   count_ff, count_in;
   logic req_fire;
   logic push;
   logic pop;

   assign req_if.ready = (count_ff != QUEUE_FULL);
   assign req_fire     = req_if.valid && req_if.ready;
   // cells outside the text area are taken and dropped
   assign push         = req_fire && in_area;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (tcgr_pkg::QPTR_W + 1)'(push) - (tcgr_pkg::QPTR_W + 1)'(pop);
   end

   // head read is registered; a write to the next head address is forwarded
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= entry;
      end
      if (push && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= entry;
      end else begin
         head_ff <= queue_mem[rd_ptr_in];
      end
   end

   // pixel walker
   logic                         gen_active_ff, gen_active_in;
   tcgr_pkg::lit_mask_type       mask_ff, mask_in;
   logic                         swap_ff, swap_in;
   logic                         wide_ff, wide_in;
   logic [tcgr_pkg::PIX_IDX_W-1:0] gen_idx_ff, gen_idx_in;
   logic [tcgr_pkg::PX_W-1:0]    gen_px_ff, gen_px_in;
   logic [23:0]                  row_off_ff, row_off_in;
   logic [23:0]                  pix_off_ff, pix_off_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_offset_ff, rsp_offset_in;
   logic [31:0] rsp_color_ff, rsp_color_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic        gen_fire;
   logic        gen_last;
   logic [23:0] next_row;
   logic [31:0] fg;
   logic [31:0] bg;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign gen_fire = gen_active_ff && out_free;
   assign gen_last = (gen_idx_ff == LAST_IDX);
   assign pop      = (count_ff != '0) && (!gen_active_ff || (gen_fire && gen_last));
   assign next_row = row_off_ff + 24'(csr_ff.line_stride);
   assign fg       = wide_ff ? tcgr_pkg::FG_32 : tcgr_pkg::FG_16;
   assign bg       = wide_ff ? tcgr_pkg::BG_32 : tcgr_pkg::BG_16;

   always_comb begin
      gen_active_in = gen_active_ff;
      mask_in       = mask_ff;
      swap_in       = swap_ff;
      wide_in       = wide_ff;
      gen_idx_in    = gen_idx_ff;
      gen_px_in     = gen_px_ff;
      row_off_in    = row_off_ff;
      pix_off_in    = pix_off_ff;
      if (gen_fire) begin
         mask_in    = mask_ff >> 1;
         gen_idx_in = gen_idx_ff + 1'b1;
         if (gen_px_ff == LAST_PX) begin
            gen_px_in  = '0;
            row_off_in = next_row;
            pix_off_in = next_row;
         end else begin
            gen_px_in  = gen_px_ff + 1'b1;
            pix_off_in = pix_off_ff + (wide_ff ? 24'd4 : 24'd2);
         end
         if (gen_last) begin
            gen_active_in = 1'b0;
         end
      end
      if (pop) begin
         gen_active_in = 1'b1;
         mask_in       = head_ff.lit_mask;
         swap_in       = head_ff.swap;
         wide_in       = head_ff.wide;
         gen_idx_in    = '0;
         gen_px_in     = '0;
         row_off_in    = head_ff.start_offset;
         pix_off_in    = head_ff.start_offset;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      if (gen_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = pix_off_ff;
         rsp_color_in  = (mask_ff[0] != swap_ff) ? fg : bg;
         rsp_last_in   = gen_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pixel_32bit    <= 1'b0;
         csr_ff.line_stride    <= 12'd640;
         csr_ff.origin_x       <= 10'd16;
         csr_ff.origin_y       <= 10'd12;
         csr_ff.columns_in_use <= 7'd48;
         csr_ff.rows_in_use    <= 6'd21;
         wr_ptr_ff             <= '0;
         rd_ptr_ff             <= '0;
         count_ff              <= '0;
         gen_active_ff         <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         csr_ff        <= csr_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         gen_active_ff <= gen_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      swap_ff       <= swap_in;
      wide_ff       <= wide_in;
      gen_idx_ff    <= gen_idx_in;
      gen_px_ff     <= gen_px_in;
      row_off_ff    <= row_off_in;
      pix_off_ff    <= pix_off_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pixel_offset = rsp_offset_ff;
   assign rsp_if.pixel_color  = rsp_color_ff;
   assign rsp_if.last_pixel   = rsp_last_ff;

`include "text_cell_glyph_renderer_macros.svh"

   `TCGR_ASSERT_NEVER(a_queue_overflow, count_ff > QUEUE_FULL, "cell queue count past depth")
   `TCGR_ASSERT_IMPLY(a_last_at_row_end, gen_fire && gen_last, gen_px_ff == LAST_PX,
                      "last pixel not at end of row")
   `TCGR_ASSERT_NEXT(a_fire_to_output, gen_fire,
                     rsp_valid_ff && (rsp_last_ff == $past(gen_last)),
                     "walker pixel did not reach output")
   `TCGR_ASSERT_IMPLY(a_pop_needs_entry, pop, (count_ff != '0 && out_free) || !gen_active_ff,
                      "pop without room or entry")

endmodule
